### hdl/prbs_rc_pkg.sv
// Shared types, register indexes, mode codes and shape table helpers for the PRBS source.
package prbs_rc_pkg;

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SOURCE_MODE     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_AMPLITUDE       = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PRBS_ORDER      = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SAMPLES_PER_BIT = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RISE_INCREMENT  = 3'd4;

    // Source mode codes.
    typedef enum logic [1:0] {
        MODE_ZERO = 2'd0,
        MODE_STEP = 2'd1,
        MODE_PRBS = 2'd2,
        MODE_IDLE = 2'd3
    } source_mode_t;

    // Field widths fixed by the register map.
    localparam int ORDER_BITS  = 5;
    localparam int COUNT_BITS  = 16;
    localparam int PHASE_BITS  = 21;
    localparam int PHASE_FRAC  = 20;
    localparam int SHAPE_BITS  = 16;

    localparam logic [PHASE_BITS-1:0] PHASE_ONE = 21'h100000;
    localparam logic [SHAPE_BITS:0]   SHAPE_ONE = 17'h10000;
    localparam logic [63:0]           PI_Q30    = 64'd3373259426;

    // Q16 value of 0.5*(1-cos(pi*k/2^tb)) for k up to half the table, by Taylor series.
    // Only evaluated at elaboration to fill the shape table.
    function automatic logic [SHAPE_BITS-1:0] half_shape(input int unsigned k,
                                                         input int unsigned tb);
        logic [63:0] a;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        int unsigned n;
        a    = (PI_Q30 * 64'(k)) >> tb;
        x2   = (a * a) >> 30;
        term = x2 >> 1;
        sum  = longint'(term);
        for (n = 2; n <= 10; n++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
            if (n[0])
            begin
                sum = sum + longint'(term);
            end
            else
            begin
                sum = sum - longint'(term);
            end
        end
        if (sum < 0)
        begin
            sum = 0;
        end
        return SHAPE_BITS'((64'(sum) + 64'd16384) >> 15);
    endfunction

    // Full-table entry: the upper half mirrors the lower half around one half.
    function automatic logic [SHAPE_BITS-1:0] shape_entry(input int unsigned k,
                                                          input int unsigned tb);
        int unsigned n_entries;
        logic [SHAPE_BITS:0] mirrored;
        n_entries = 32'd1 << tb;
        if (k <= (n_entries >> 1))
        begin
            return half_shape(k, tb);
        end
        mirrored = SHAPE_ONE - {1'b0, half_shape(n_entries - k, tb)};
        return mirrored[SHAPE_BITS-1:0];
    endfunction

endpackage

### hdl/prbs_raised_cosine_source.sv
// Top level of the PRBS and raised-cosine step test waveform source.
//
// Every accepted restart word is one sample tick and yields exactly one output word
// (sample_value, current_bit). The block sustains one sample per clock: the state update,
// the registered shape-table read and the amplitude multiply form a three-stage pipeline,
// so a result is registered at each stage before it is presented, and a new tick can be taken
// every cycle while out_ready is high. The shape table holds 2^SHAPE_TABLE_BITS Q16 entries
// of 0.5*(1-cos(pi*x)) and is read once per sample. Configuration must be written through
// cfg_wr_en/cfg_index/cfg_data while the source is idle (the block does not check); unused indexes are ignored.
module prbs_raised_cosine_source
    import prbs_rc_pkg::*;
#(
    parameter int SHAPE_TABLE_BITS = 10,
    parameter int SAMPLE_BITS      = 16,
    parameter int MAX_ORDER        = 31,
    localparam int CfgDataBits     = (SAMPLE_BITS > PHASE_BITS) ? SAMPLE_BITS : PHASE_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration write port.
    input  logic                          cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [CfgDataBits-1:0]        cfg_data,
    // Sample tick channel.
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          restart,
    // Sample output channel.
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] sample_value,
    output logic                          current_bit
);

    localparam int TableN   = 1 << SHAPE_TABLE_BITS;
    localparam int RstOrder = (MAX_ORDER < 7) ? MAX_ORDER : 7;
    localparam int ProdBits = SAMPLE_BITS + SHAPE_BITS + 2;

    typedef logic [SHAPE_BITS-1:0] shape_rom_t [TableN];

    function automatic shape_rom_t build_rom();
        shape_rom_t rom;
        for (int k = 0; k < TableN; k++)
        begin
            rom[k] = shape_entry(k, SHAPE_TABLE_BITS);
        end
        return rom;
    endfunction

    localparam shape_rom_t SHAPE_ROM = build_rom();

    localparam logic [MAX_ORDER-1:0] RST_SHIFT =
        MAX_ORDER'((64'd1 << RstOrder) - 64'd1);

    // Configuration registers.
    source_mode_t                   mode_reg;
    logic signed [SAMPLE_BITS-1:0]  amplitude_reg;
    logic [ORDER_BITS-1:0]          order_reg;
    logic [COUNT_BITS-1:0]          spb_reg;
    logic [PHASE_BITS-1:0]          rise_reg;

    // Waveform state.
    logic [MAX_ORDER-1:0]           shift_reg,    shift_next;
    logic                           prev_bit_reg, prev_bit_next;
    logic [COUNT_BITS-1:0]          position_reg, position_next;
    logic [PHASE_BITS-1:0]          phase_reg,    phase_next;

    // Pipeline stage registers.
    logic                           s1_valid_reg;
    logic [SHAPE_TABLE_BITS-1:0]    s1_index_reg;
    logic                           s1_done_reg;
    logic                           s1_cur_reg;
    logic                           s1_prev_reg;
    logic                           s2_valid_reg;
    logic [SHAPE_BITS-1:0]          s2_shape_reg;
    logic                           s2_done_reg;
    logic                           s2_cur_reg;
    logic                           s2_prev_reg;
    logic                           out_valid_reg;
    logic [SAMPLE_BITS-1:0]         sample_reg, sample_next;
    logic                           bit_reg;

    // Stage handshakes.
    logic                           s3_ready;
    logic                           s2_ready;
    logic                           s1_ready;
    logic                           in_accept;

    // State update helpers.
    logic [ORDER_BITS-1:0]          eff_order;
    logic [MAX_ORDER-1:0]           order_mask;
    logic [MAX_ORDER-1:0]           base_shift;
    logic                           base_prev;
    logic [COUNT_BITS-1:0]          base_position;
    logic [PHASE_BITS-1:0]          base_phase;
    logic [PHASE_BITS:0]            phase_sum;
    logic [PHASE_BITS-1:0]          phase_sat;
    logic [COUNT_BITS:0]            position_inc;
    logic                           feedback;
    logic [MAX_ORDER:0]             shift_ext;
    logic [MAX_ORDER-1:0]           shifted;

    // Output stage helpers.
    logic [SHAPE_BITS:0]            shape_val;
    logic [SHAPE_BITS:0]            factor;
    logic signed [ProdBits-1:0]     amp_ext;
    logic signed [ProdBits-1:0]     factor_ext;
    logic signed [ProdBits-1:0]     product;
    logic signed [ProdBits-1:0]     rounded;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_PRBS;
            amplitude_reg <= SAMPLE_BITS'(1 << (SAMPLE_BITS - 2));
            order_reg     <= ORDER_BITS'(7);
            spb_reg       <= COUNT_BITS'(16);
            rise_reg      <= PHASE_BITS'(262144);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_SOURCE_MODE:     mode_reg      <= source_mode_t'(cfg_data[1:0]);
                REG_AMPLITUDE:       amplitude_reg <= cfg_data[SAMPLE_BITS-1:0];
                REG_PRBS_ORDER:      order_reg     <= cfg_data[ORDER_BITS-1:0];
                REG_SAMPLES_PER_BIT: spb_reg       <= cfg_data[COUNT_BITS-1:0];
                REG_RISE_INCREMENT:  rise_reg      <= cfg_data[PHASE_BITS-1:0];
                default:             ;
            endcase
        end
    end

    // Backpressure: each stage loads when it is empty or its successor moves on.
    assign s3_ready  = !out_valid_reg || out_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_ready  = s1_ready;
    assign in_accept = in_valid && s1_ready;

    // Effective LFSR length, clamped to the supported range, and its mask.
    always_comb
    begin
        if (order_reg < ORDER_BITS'(2))
        begin
            eff_order = ORDER_BITS'(2);
        end
        else if (order_reg > ORDER_BITS'(MAX_ORDER))
        begin
            eff_order = ORDER_BITS'(MAX_ORDER);
        end
        else
        begin
            eff_order = order_reg;
        end
        for (int i = 0; i < MAX_ORDER; i++)
        begin
            order_mask[i] = (i < int'(eff_order));
        end
    end

    // Next state for one sample tick; restart reloads the state first.
    always_comb
    begin
        base_shift    = restart ? order_mask : shift_reg;
        base_prev     = restart ? 1'b0 : prev_bit_reg;
        base_position = restart ? '0 : position_reg;
        base_phase    = restart ? '0 : phase_reg;

        // Phase accumulator saturating at one.
        phase_sum = {1'b0, base_phase} + {1'b0, rise_reg};
        if (phase_sum > {1'b0, PHASE_ONE})
        begin
            phase_sat = PHASE_ONE;
        end
        else
        begin
            phase_sat = phase_sum[PHASE_BITS-1:0];
        end

        // LFSR feedback taps by length.
        case (eff_order) inside
            5'd5, 5'd11: feedback = base_shift[0] ^ base_shift[2];
            5'd9:        feedback = base_shift[0] ^ base_shift[4];
            5'd13:       feedback = base_shift[0] ^ base_shift[1] ^ base_shift[2]
                                    ^ base_shift[5];
            5'd23:       feedback = base_shift[0] ^ base_shift[5];
            5'd31:       feedback = base_shift[0] ^ base_shift[3];
            default:     feedback = base_shift[0] ^ base_shift[1];
        endcase

        // Shift right and OR the feedback into the top bit of the active length.
        // Bits left above a shortened length still shift down into that top bit.
        shift_ext = {1'b0, base_shift};
        for (int i = 0; i < MAX_ORDER; i++)
        begin
            if (i + 1 < int'(eff_order))
            begin
                shifted[i] = shift_ext[i + 1];
            end
            else if (i + 1 == int'(eff_order))
            begin
                shifted[i] = shift_ext[i + 1] | feedback;
            end
            else
            begin
                shifted[i] = 1'b0;
            end
        end

        position_inc  = {1'b0, base_position} + 1'b1;
        shift_next    = base_shift;
        prev_bit_next = base_prev;
        position_next = base_position;
        phase_next    = phase_sat;

        // Bit period counting only runs in PRBS mode.
        if (mode_reg == MODE_PRBS)
        begin
            if (position_inc >= {1'b0, spb_reg})
            begin
                position_next = '0;
                prev_bit_next = base_shift[0];
                shift_next    = shifted;
                phase_next    = '0;
            end
            else
            begin
                position_next = position_inc[COUNT_BITS-1:0];
            end
        end
    end

    // Waveform state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg    <= RST_SHIFT;
            prev_bit_reg <= 1'b0;
            position_reg <= '0;
            phase_reg    <= '0;
        end
        else if (in_accept)
        begin
            shift_reg    <= shift_next;
            prev_bit_reg <= prev_bit_next;
            position_reg <= position_next;
            phase_reg    <= phase_next;
        end
    end

    // Stage one: table address and bit levels of the tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_index_reg <= phase_next[PHASE_FRAC-1 -: SHAPE_TABLE_BITS];
            s1_done_reg  <= (phase_next >= PHASE_ONE);
            s1_cur_reg   <= (mode_reg == MODE_PRBS) && shift_next[0];
            s1_prev_reg  <= prev_bit_next;
        end
    end

    // Stage two: registered shape table read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_shape_reg <= SHAPE_ROM[s1_index_reg];
            s2_done_reg  <= s1_done_reg;
            s2_cur_reg   <= s1_cur_reg;
            s2_prev_reg  <= s1_prev_reg;
        end
    end

    // Stage three: pick the edge factor and scale by the amplitude with rounding.
    always_comb
    begin
        shape_val = s2_done_reg ? SHAPE_ONE : {1'b0, s2_shape_reg};
        case (mode_reg)
            MODE_STEP:
            begin
                factor = shape_val;
            end
            MODE_PRBS:
            begin
                if (s2_prev_reg == s2_cur_reg)
                begin
                    factor = s2_cur_reg ? SHAPE_ONE : '0;
                end
                else
                begin
                    factor = s2_cur_reg ? shape_val : SHAPE_ONE - shape_val;
                end
            end
            default:
            begin
                factor = '0;
            end
        endcase
        amp_ext     = ProdBits'(amplitude_reg);
        factor_ext  = $signed(ProdBits'(factor));
        product     = amp_ext * factor_ext;
        rounded     = product + ProdBits'(32768);
        sample_next = rounded[SAMPLE_BITS+SHAPE_BITS-1:SHAPE_BITS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s3_ready)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid_reg)
        begin
            sample_reg <= sample_next;
            bit_reg    <= s2_cur_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sample_value = $signed(sample_reg);
    assign current_bit  = bit_reg;

endmodule
